// File: rtl/core/bed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bed_pkg
// shared types, character codes and helpers of the backslash escape decoder
// ----------------------------------------------------------------------------
package bed_pkg;

    localparam int unsigned BED_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] END_BYTE_RST = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    // work for the back end: zero to two decoded bytes, then maybe the end byte
    typedef struct packed {
        logic [1:0] byte_cnt;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       has_end;
    } t_cmd;

    // returns {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            res = {1'b1, c[3:0] + 4'd9};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bed_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bed_front
// accepts raw bytes, tracks the escape state and builds one command per byte
// ----------------------------------------------------------------------------
module bed_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bed_pkg::t_in_item i_in,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output bed_pkg::t_cmd        o_cmd
);
    import bed_pkg::*;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX1,
        MODE_HEX2
    } t_mode;

    t_mode      r_mode, n_mode;
    logic [3:0] r_nib, n_nib;
    logic       r_nib_ok, n_nib_ok;

    logic       accept;
    logic [4:0] hv;
    logic [7:0] flush_byte;
    logic       do_flush;
    t_cmd       cmd;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign hv         = hex_decode(i_in.in_byte);

    always_comb begin
        n_mode     = r_mode;
        n_nib      = r_nib;
        n_nib_ok   = r_nib_ok;
        cmd        = '0;
        flush_byte = 8'h00;
        do_flush   = 1'b0;

        unique case (r_mode)
            MODE_PLAIN: begin
                if (i_in.in_byte == CH_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    cmd.byte_cnt = 2'd1;
                    cmd.byte0    = i_in.in_byte;
                end
            end
            MODE_ESC: begin
                n_mode       = MODE_PLAIN;
                cmd.byte_cnt = 2'd1;
                case (i_in.in_byte)
                    CH_BACKSLASH: cmd.byte0 = CH_BACKSLASH;
                    CH_LOWER_N:   cmd.byte0 = CH_NEWLINE;
                    CH_LOWER_R:   cmd.byte0 = CH_RETURN;
                    CH_LOWER_T:   cmd.byte0 = CH_TAB;
                    CH_LOWER_X: begin
                        n_mode       = MODE_HEX1;
                        cmd.byte_cnt = 2'd0;
                    end
                    default: begin
                        // unknown escape passes through as two bytes
                        cmd.byte_cnt = 2'd2;
                        cmd.byte0    = CH_BACKSLASH;
                        cmd.byte1    = i_in.in_byte;
                    end
                endcase
            end
            MODE_HEX1: begin
                n_nib    = hv[4] ? hv[3:0] : 4'h0;
                n_nib_ok = hv[4];
                n_mode   = MODE_HEX2;
            end
            MODE_HEX2: begin
                n_mode       = MODE_PLAIN;
                cmd.byte_cnt = 2'd1;
                if (!r_nib_ok) begin
                    cmd.byte0 = 8'h00;
                end else if (!hv[4]) begin
                    cmd.byte0 = {4'h0, r_nib};
                end else begin
                    cmd.byte0 = {r_nib, hv[3:0]};
                end
            end
            default: n_mode = MODE_PLAIN;
        endcase

        if (i_in.in_last) begin
            // flush a pending partial escape, then close the line
            unique case (n_mode)
                MODE_ESC: begin
                    do_flush   = 1'b1;
                    flush_byte = CH_BACKSLASH;
                end
                MODE_HEX1: begin
                    do_flush   = 1'b1;
                    flush_byte = 8'h00;
                end
                MODE_HEX2: begin
                    do_flush   = 1'b1;
                    flush_byte = n_nib_ok ? {4'h0, n_nib} : 8'h00;
                end
                default: do_flush = 1'b0;
            endcase
            if (do_flush) begin
                if (cmd.byte_cnt == 2'd0) begin
                    cmd.byte0 = flush_byte;
                end else begin
                    cmd.byte1 = flush_byte;
                end
                cmd.byte_cnt = cmd.byte_cnt + 2'd1;
            end
            n_mode      = MODE_PLAIN;
            n_nib       = 4'h0;
            n_nib_ok    = 1'b0;
            cmd.has_end = 1'b1;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.byte_cnt != 2'd0) || cmd.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_nib    <= 4'h0;
            r_nib_ok <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_nib    <= n_nib;
            r_nib_ok <= n_nib_ok;
        end
    end

`ifndef SYNTHESIS
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("front pushes into a full queue");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.in_last) |=> (r_mode == MODE_PLAIN && !r_nib_ok))
        else $error("escape state survives the end of a line");
`endif

endmodule
`default_nettype wire

// File: rtl/core/bed_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bed_queue
// short command queue that decouples the front end from the back end
// ----------------------------------------------------------------------------
module bed_queue #(
    parameter int unsigned DEPTH = bed_pkg::BED_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire bed_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output bed_pkg::t_cmd      o_cmd
);
    import bed_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue underflow");
`endif

endmodule
`default_nettype wire

// File: rtl/core/bed_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bed_back
// walks through each queued command and drives one result byte per transfer
// ----------------------------------------------------------------------------
module bed_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire bed_pkg::t_cmd i_cmd,
    output logic               o_pop,
    input  wire logic [7:0]    i_end_byte,
    output bed_pkg::t_out_item o_out,
    output logic               o_out_valid,
    input  wire logic          i_out_stall
);
    import bed_pkg::*;

    logic [1:0] r_idx;
    logic [1:0] total;
    logic       load;
    logic       is_final;
    t_out_item  r_out, n_out;
    logic       r_out_valid;

    assign total    = i_cmd.byte_cnt + {1'b0, i_cmd.has_end};
    assign load     = i_q_valid && (!r_out_valid || !i_out_stall);
    assign is_final = (r_idx == total - 2'd1);
    assign o_pop    = load && is_final;

    always_comb begin
        n_out = '0;
        if (r_idx < i_cmd.byte_cnt) begin
            n_out.out_byte = r_idx[0] ? i_cmd.byte1 : i_cmd.byte0;
            n_out.out_last = 1'b0;
        end else begin
            n_out.out_byte = i_end_byte;
            n_out.out_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_final ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx < total))
        else $error("result index runs past its command");
    a_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

// File: rtl/core/backslash_escape_decoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder_core
// decodes backslash escapes in a byte stream, one raw byte per transfer
// ----------------------------------------------------------------------------
// input channel: i_in (byte and last mark) with i_in_valid, o_in_stall
// output channel: o_out (byte and end mark) with o_out_valid, i_out_stall
// config channel: i_cfg_data with i_cfg_valid, o_cfg_ready; sets the end byte
//   that closes each line, always ready, write only while the block is idle
// each input byte gives zero to three result bytes; a marked last byte
//   flushes any partial escape and appends the end byte with out_last set
// path: an accepted input byte is written into the command queue, and its first
//   result is then loaded into the output register that drives o_out
// throughput: one input byte per cycle while each gives at most one result and
//   i_out_stall is low; the output side moves one result per cycle, so bytes
//   with two or three results hold it longer and the command queue absorbs
//   this until it fills, then o_in_stall rises
// when i_out_stall is high the output register holds its result, the queue
//   fills and the input stalls; no result is lost
// reset (synchronous, active low) clears the escape state, the queue and the
//   output valid, and sets the end byte to line feed
// ----------------------------------------------------------------------------
module backslash_escape_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = bed_pkg::BED_QUEUE_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bed_pkg::t_in_item  i_in,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output bed_pkg::t_out_item      o_out,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [7:0]         i_cfg_data
);
    import bed_pkg::*;

    logic [7:0] r_end_byte;
    logic       q_full;
    logic       q_valid;
    logic       push;
    logic       pop;
    t_cmd       push_cmd;
    t_cmd       head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_byte <= END_BYTE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_end_byte <= i_cfg_data;
        end
    end

    bed_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    bed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    bed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_end_byte  (r_end_byte),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule
`default_nettype wire
